// File: design/yuvrgb_pkg.sv
// Shared types, constants and helpers for the YUYV to RGB converter.
package yuvrgb_pkg;

  localparam int SAMPLE_W = 8;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W    = 15;
  localparam int ACC_W    = 32;
  localparam int FRAC_BITS = 20;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t COEF_Y  = 32'sd1220542;
  localparam acc_t COEF_UB = 32'sd2116026;
  localparam acc_t COEF_UG = -32'sd409993;
  localparam acc_t COEF_VG = -32'sd852492;
  localparam acc_t COEF_VR = 32'sd1673527;
  localparam acc_t HALF_LSB = acc_t'(1) <<< (FRAC_BITS - 1);

  localparam logic [SAMPLE_W-1:0] CHROMA_BIAS = SAMPLE_W'(128);
  localparam logic [SAMPLE_W-1:0] LUMA_BIAS   = SAMPLE_W'(16);
  localparam logic [SAMPLE_W-1:0] CHAN_MAX    = SAMPLE_W'(8'hff);

  typedef struct packed {
    acc_t red;
    acc_t green;
    acc_t blue;
  } chroma_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } marks_t;

  // floor(acc / 2^FRAC_BITS) clamped to 0..255
  function automatic logic [SAMPLE_W-1:0] to_channel(input acc_t acc);
    acc_t q;
    q = acc >>> FRAC_BITS;
    if (acc < 0) begin
      to_channel = '0;
    end else if (q > acc_t'(CHAN_MAX)) begin
      to_channel = CHAN_MAX;
    end else begin
      to_channel = q[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// File: design/yuvrgb_chroma.sv
// Shared chroma products for one YUYV group, registered at the first stage.
module yuvrgb_chroma
  import yuvrgb_pkg::*;
(
  input  logic                clk,
  input  logic                load,
  input  logic [SAMPLE_W-1:0] chroma_blue,
  input  logic [SAMPLE_W-1:0] chroma_red,
  output chroma_t             terms
);

  logic signed [SAMPLE_W:0] u;
  logic signed [SAMPLE_W:0] v;
  chroma_t terms_r;
  chroma_t terms_nxt;

  assign u = $signed({1'b0, chroma_blue}) - $signed({1'b0, CHROMA_BIAS});
  assign v = $signed({1'b0, chroma_red}) - $signed({1'b0, CHROMA_BIAS});

  always_comb begin
    terms_nxt.red   = HALF_LSB + acc_t'(v) * COEF_VR;
    terms_nxt.green = HALF_LSB + acc_t'(v) * COEF_VG + acc_t'(u) * COEF_UG;
    terms_nxt.blue  = HALF_LSB + acc_t'(u) * COEF_UB;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms = terms_r;

endmodule

// File: design/yuvrgb_lane.sv
// One pixel lane: registered luma product, then chroma add and clamp.
module yuvrgb_lane
  import yuvrgb_pkg::*;
(
  input  logic                clk,
  input  logic                load,
  input  logic [SAMPLE_W-1:0] luma,
  input  chroma_t             terms,
  output pixel_t              pixel
);

  logic [SAMPLE_W-1:0] luma_off;
  acc_t luma_r;
  acc_t luma_nxt;

  assign luma_off = (luma < LUMA_BIAS) ? '0 : luma - LUMA_BIAS;
  assign luma_nxt = acc_t'($signed({1'b0, luma_off})) * COEF_Y;

  always_ff @(posedge clk) begin
    if (load) begin
      luma_r <= luma_nxt;
    end
  end

  always_comb begin
    pixel.red   = to_channel(luma_r + terms.red);
    pixel.green = to_channel(luma_r + terms.green);
    pixel.blue  = to_channel(luma_r + terms.blue);
  end

endmodule

// File: design/yuvrgb_pos.sv
// Frame size registers and pair column / row counters for end marks.
module yuvrgb_pos
  import yuvrgb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 step,
  output marks_t               marks
);

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2((MAX_WIDTH + 1) / 2) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [DIM_W-1:0] WIDTH_LIM  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_LIM = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] WIDTH_MIN  = DIM_W'(2);
  localparam logic [DIM_W-1:0] HEIGHT_MIN = DIM_W'(1);

  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] w_ext, h_ext, w_eff, h_eff, last_col, last_row;
  logic rend, fend;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  assign w_ext = DIM_W'(width_r);
  assign h_ext = DIM_W'(height_r);
  assign w_eff = (w_ext < WIDTH_MIN) ? WIDTH_MIN : ((w_ext > WIDTH_LIM) ? WIDTH_LIM : w_ext);
  assign h_eff = (h_ext < HEIGHT_MIN) ? HEIGHT_MIN :
                 ((h_ext > HEIGHT_LIM) ? HEIGHT_LIM : h_ext);
  assign last_col = (w_eff - DIM_W'(1)) >> 1;
  assign last_row = h_eff - DIM_W'(1);

  assign rend = DIM_W'(col_r) >= last_col;
  assign fend = rend && (DIM_W'(row_r) >= last_row);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (rend) begin
        col_nxt = '0;
        row_nxt = fend ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  assign marks.row_end   = rend;
  assign marks.frame_end = fend;

endmodule

// File: design/yuv422_to_bgra_bt601.sv
// Top level: YUYV group to two BT.601 RGB pixels with row and frame end marks.
//
// Input channel (in_*): one YUYV group per beat, valid/ready.
// Output channel (out_*): two RGB pixels plus row_end / frame_end per beat.
// Config channel (cfg_*): index 0 frame_width, 1 frame_height; always ready.
//   Other indexes are ignored. Write only while the block is idle.
// Pipeline: stage one holds the chroma products and the two luma
//   products; stage two adds, rounds, clamps and holds the result in
//   the output registers.
// Throughput: one beat per cycle while out_ready is high; two pixel lanes run side by side.
// Stalls: each stage advances when empty or when the stage after it moves,
//   so a beat is taken even while a finished result waits, until both
//   stages are full. out_ready low then drops in_ready in the same cycle.
// Reset: both stages empty, counters at zero, 640 x 480 frame size.
// End marks come from the counters at the moment a beat is taken.
module yuv422_to_bgra_bt601
  import yuvrgb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  in_luma_first,
  input  logic [SAMPLE_W-1:0]  in_chroma_blue,
  input  logic [SAMPLE_W-1:0]  in_luma_second,
  input  logic [SAMPLE_W-1:0]  in_chroma_red,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  out_red_first,
  output logic [SAMPLE_W-1:0]  out_green_first,
  output logic [SAMPLE_W-1:0]  out_blue_first,
  output logic [SAMPLE_W-1:0]  out_red_second,
  output logic [SAMPLE_W-1:0]  out_green_second,
  output logic [SAMPLE_W-1:0]  out_blue_second,
  output logic                 out_row_end,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic    s1_valid_r, s1_valid_nxt;
  logic    s2_valid_r, s2_valid_nxt;
  logic    s1_load, s2_load, in_fire;
  marks_t  marks, s1_marks_r, s2_marks_r;
  chroma_t terms;
  pixel_t  pix_first, pix_second, first_r, second_r;

  assign s2_load  = !s2_valid_r || out_ready;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_ready = s1_load;
  assign in_fire  = in_valid && s1_load;
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt = s1_load ? in_valid : s1_valid_r;
  assign s2_valid_nxt = s2_load ? s1_valid_r : s2_valid_r;

  yuvrgb_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (in_fire),
    .marks     (marks)
  );

  yuvrgb_chroma u_chroma (
    .clk         (clk),
    .load        (s1_load),
    .chroma_blue (in_chroma_blue),
    .chroma_red  (in_chroma_red),
    .terms       (terms)
  );

  yuvrgb_lane u_lane_first (
    .clk   (clk),
    .load  (s1_load),
    .luma  (in_luma_first),
    .terms (terms),
    .pixel (pix_first)
  );

  yuvrgb_lane u_lane_second (
    .clk   (clk),
    .load  (s1_load),
    .luma  (in_luma_second),
    .terms (terms),
    .pixel (pix_second)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_marks_r <= marks;
    end
    if (s2_load) begin
      s2_marks_r <= s1_marks_r;
      first_r    <= pix_first;
      second_r   <= pix_second;
    end
  end

  assign out_valid        = s2_valid_r;
  assign out_red_first    = first_r.red;
  assign out_green_first  = first_r.green;
  assign out_blue_first   = first_r.blue;
  assign out_red_second   = second_r.red;
  assign out_green_second = second_r.green;
  assign out_blue_second  = second_r.blue;
  assign out_row_end      = s2_marks_r.row_end;
  assign out_frame_end    = s2_marks_r.frame_end;

`ifndef SYNTHESIS
  a_frame_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame_end without row_end");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_advance_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_valid_r) |=> s2_valid_r)
    else $error("stage one beat not moved into empty stage two");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r && !out_ready) |-> !in_ready)
    else $error("beat accepted while both stages full and stalled");

  a_no_lost_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_ready) |=> s2_valid_r)
    else $error("output beat dropped during stall");
`endif

endmodule
